// File: design/rgd_pkg.sv
// package of types, constants and helpers for the run-length grid decoder
`timescale 1ns / 1ps

package rgd_pkg;

  localparam logic [7:0] MIN_WIDTH = 8'd8;

  typedef enum logic [1:0] {
    PH_WIDTH,
    PH_HEIGHT,
    PH_COUNT,
    PH_VALUE
  } phase_t;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_EMIT,
    ST_ERROR
  } ctrl_state_t;

  typedef struct packed {
    logic take_byte;
    logic load_seg;
    logic load_err;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_width;
    logic value_byte;
    logic seg_pending;
    logic out_free;
  } dp_status_t;

  // log2 of the smallest power of two at or above w, for w of 1 or more
  function automatic logic [3:0] shift_for(input logic [7:0] w);
    logic [7:0] rest;
    logic [3:0] s;
    int i;
    rest = w - 8'd1;
    s = 4'd0;
    for (i = 0; i < 8; i++) begin
      if (rest[i]) begin
        s = 4'(i + 1);
      end
    end
    return s;
  endfunction

endpackage

// File: design/rgd_if.sv
// stream interfaces for the byte input and the fill segment output
`timescale 1ns / 1ps

interface rgd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_level;

  modport source (output valid, output data_byte, output start_of_level, input ready);
  modport sink (input valid, input data_byte, input start_of_level, output ready);
endinterface

interface rgd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fill_address;
  logic [7:0]  fill_length;
  logic [7:0]  fill_value;
  logic        grid_done;
  logic        bad_header;

  modport source (
    output valid, output fill_address, output fill_length, output fill_value,
    output grid_done, output bad_header, input ready
  );
  modport sink (
    input valid, input fill_address, input fill_length, input fill_value,
    input grid_done, input bad_header, output ready
  );
endinterface

// File: design/rle_grid_decoder_8bit.sv
// top level of the run-length grid decoder
// header and count bytes: one transfer per cycle, no result
// value byte: taken in ACCEPT, one cycle per row segment in EMIT while output is free
// a run splits into one segment per row it touches, all through the single output register
// a narrow width byte goes through the error state and gives the error result
// synchronous rst clears control state; the decoder idles until a start_of_level byte
`timescale 1ns / 1ps

module rle_grid_decoder_8bit (
  input  logic      clk,
  input  logic      rst,
  rgd_in_if.sink    in_ch,
  rgd_out_if.source out_ch
);

  rgd_pkg::dp_cmd_t    cmd;
  rgd_pkg::dp_status_t status;

  rgd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rgd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (in_ch.data_byte),
    .start_of_level (in_ch.start_of_level),
    .cmd            (cmd),
    .status         (status),
    .out_ch         (out_ch)
  );

endmodule

// File: design/rgd_ctrl.sv
// controller state machine of the run-length grid decoder
`timescale 1ns / 1ps

module rgd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rgd_pkg::dp_status_t status,
  output rgd_pkg::dp_cmd_t    cmd
);

  rgd_pkg::ctrl_state_t state;
  rgd_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgd_pkg::ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rgd_pkg::ST_ACCEPT: begin
        if (in_valid) begin
          if (status.bad_width) begin
            state_next = rgd_pkg::ST_ERROR;
          end else if (status.value_byte) begin
            state_next = rgd_pkg::ST_EMIT;
          end
        end
      end
      rgd_pkg::ST_EMIT: begin
        if (!status.seg_pending) begin
          state_next = rgd_pkg::ST_ACCEPT;
        end
      end
      rgd_pkg::ST_ERROR: begin
        if (status.out_free) begin
          state_next = rgd_pkg::ST_ACCEPT;
        end
      end
      default: state_next = rgd_pkg::ST_ACCEPT;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.take_byte = 1'b0;
    cmd.load_seg  = 1'b0;
    cmd.load_err  = 1'b0;
    case (state)
      rgd_pkg::ST_ACCEPT: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
      end
      rgd_pkg::ST_EMIT: begin
        cmd.load_seg = status.seg_pending && status.out_free;
      end
      rgd_pkg::ST_ERROR: begin
        cmd.load_err = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: design/rgd_datapath.sv
// datapath: header and run registers, segment arithmetic and output register
`timescale 1ns / 1ps

module rgd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          data_byte,
  input  logic                start_of_level,
  input  rgd_pkg::dp_cmd_t    cmd,
  output rgd_pkg::dp_status_t status,
  rgd_out_if.source           out_ch
);

  rgd_pkg::phase_t phase;
  rgd_pkg::phase_t phase_next;
  logic [7:0] grid_width, grid_width_next;
  logic [7:0] grid_height, grid_height_next;
  logic [3:0] pitch_shift, pitch_shift_next;
  logic [7:0] current_row, current_row_next;
  logic [7:0] current_column, current_column_next;
  logic [7:0] run_remaining, run_remaining_next;
  logic [7:0] run_value, run_value_next;
  logic       finished, finished_next;

  logic       out_valid;
  logic [15:0] out_address;
  logic [7:0]  out_length;
  logic [7:0]  out_value;
  logic        out_done;
  logic        out_bad;

  logic            ignored;
  rgd_pkg::phase_t eff_phase;
  logic            width_bad;
  logic [7:0]      room;
  logic [7:0]      seg_len;
  logic [7:0]      col_sum;
  logic [7:0]      row_inc;
  logic [15:0]     seg_addr;
  logic            row_end;
  logic            seg_done;

  assign ignored   = !start_of_level && finished;
  assign eff_phase = start_of_level ? rgd_pkg::PH_WIDTH : phase;
  assign width_bad = (data_byte < rgd_pkg::MIN_WIDTH) || (data_byte == 8'd0);

  assign room     = grid_width - current_column;
  assign seg_len  = (run_remaining < room) ? run_remaining : room;
  assign col_sum  = current_column + seg_len;
  assign row_inc  = current_row + 8'd1;
  assign seg_addr = ({8'd0, current_row} << pitch_shift) + {8'd0, current_column};
  assign row_end  = (col_sum == grid_width);
  assign seg_done = row_end && (row_inc == grid_height);

  assign status.bad_width   = !ignored && (eff_phase == rgd_pkg::PH_WIDTH) && width_bad;
  assign status.value_byte  = !ignored && (eff_phase == rgd_pkg::PH_VALUE);
  assign status.seg_pending = (run_remaining != 8'd0) && !finished &&
                              (current_column < grid_width);
  assign status.out_free    = !out_valid || out_ch.ready;

  always_comb begin
    phase_next          = phase;
    grid_width_next     = grid_width;
    grid_height_next    = grid_height;
    pitch_shift_next    = pitch_shift;
    current_row_next    = current_row;
    current_column_next = current_column;
    run_remaining_next  = run_remaining;
    run_value_next      = run_value;
    finished_next       = finished;
    if (cmd.take_byte && !ignored) begin
      if (start_of_level) begin
        finished_next       = 1'b0;
        phase_next          = rgd_pkg::PH_WIDTH;
        current_row_next    = 8'd0;
        current_column_next = 8'd0;
        run_remaining_next  = 8'd0;
        run_value_next      = 8'd0;
      end
      case (eff_phase)
        rgd_pkg::PH_WIDTH: begin
          grid_width_next = data_byte;
          if (width_bad) begin
            pitch_shift_next = 4'd0;
            finished_next    = 1'b1;
          end else begin
            pitch_shift_next = rgd_pkg::shift_for(data_byte);
            phase_next       = rgd_pkg::PH_HEIGHT;
          end
        end
        rgd_pkg::PH_HEIGHT: begin
          grid_height_next = data_byte;
          if (data_byte == 8'd0) begin
            finished_next = 1'b1;
          end
          phase_next = rgd_pkg::PH_COUNT;
        end
        rgd_pkg::PH_COUNT: begin
          run_remaining_next = data_byte;
          phase_next         = rgd_pkg::PH_VALUE;
        end
        rgd_pkg::PH_VALUE: begin
          run_value_next = data_byte;
          phase_next     = rgd_pkg::PH_COUNT;
        end
        default: ;
      endcase
    end else if (cmd.load_seg) begin
      current_column_next = col_sum;
      run_remaining_next  = run_remaining - seg_len;
      if (row_end) begin
        current_column_next = 8'd0;
        current_row_next    = row_inc;
        if (seg_done) begin
          finished_next      = 1'b1;
          run_remaining_next = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= rgd_pkg::PH_WIDTH;
      grid_width     <= 8'd0;
      grid_height    <= 8'd0;
      pitch_shift    <= 4'd0;
      current_row    <= 8'd0;
      current_column <= 8'd0;
      run_remaining  <= 8'd0;
      run_value      <= 8'd0;
      finished       <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      grid_width     <= grid_width_next;
      grid_height    <= grid_height_next;
      pitch_shift    <= pitch_shift_next;
      current_row    <= current_row_next;
      current_column <= current_column_next;
      run_remaining  <= run_remaining_next;
      run_value      <= run_value_next;
      finished       <= finished_next;
      if (cmd.load_seg || cmd.load_err) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.load_seg) begin
      out_address <= seg_addr;
      out_length  <= seg_len;
      out_value   <= run_value;
      out_done    <= seg_done;
      out_bad     <= 1'b0;
    end else if (cmd.load_err) begin
      out_address <= 16'd0;
      out_length  <= 8'd0;
      out_value   <= 8'd0;
      out_done    <= 1'b0;
      out_bad     <= 1'b1;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.fill_address = out_address;
  assign out_ch.fill_length  = out_length;
  assign out_ch.fill_value   = out_value;
  assign out_ch.grid_done    = out_done;
  assign out_ch.bad_header   = out_bad;

endmodule

// File: design/rgd_checker.sv
// port checker for the run-length grid decoder and its bind
`timescale 1ns / 1ps

module rgd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] fill_address,
  input logic [7:0]  fill_length,
  input logic [7:0]  fill_value,
  input logic        grid_done,
  input logic        bad_header
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(fill_address) && $stable(fill_length) &&
      $stable(fill_value) && $stable(grid_done) && $stable(bad_header))
    else $error("stalled result changed");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_header |-> fill_address == 16'd0 && fill_length == 8'd0 &&
      fill_value == 8'd0 && !grid_done)
    else $error("error result carries segment fields");

  a_segment_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_header |-> fill_length != 8'd0)
    else $error("empty fill segment");

endmodule

bind rle_grid_decoder_8bit rgd_checker u_rgd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .fill_address (out_ch.fill_address),
  .fill_length  (out_ch.fill_length),
  .fill_value   (out_ch.fill_value),
  .grid_done    (out_ch.grid_done),
  .bad_header   (out_ch.bad_header)
);
